@@ hdl/fpf_pkg.sv @@
// ----------------------------------------------------------------------------
// fpf_pkg
// Shared types, register indexes and constants of the frame packet fragmenter.
// ----------------------------------------------------------------------------
package fpf_pkg;

    localparam int SIZE_BITS = 24;
    localparam int PB_W      = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 11;
    localparam int BEAT_W    = 3;

    localparam logic [PB_W-1:0] PAYLOAD_MAX     = 11'd1444;
    localparam logic [PB_W-1:0] PAYLOAD_RESET   = 11'd1444;
    localparam logic [7:0]      MAX_PKT_RESET   = 8'd240;
    localparam logic [7:0]      FORMAT_RESET    = 8'h02;
    localparam logic [7:0]      LAST_FLAG       = 8'h10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKETS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_CODE   = 2'd2;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // beats of a packet-opening byte
    localparam logic [BEAT_W-1:0] BEAT_ID    = 3'd0;
    localparam logic [BEAT_W-1:0] BEAT_FLAGS = 3'd1;
    localparam logic [BEAT_W-1:0] BEAT_FMT   = 3'd2;
    localparam logic [BEAT_W-1:0] BEAT_INDEX = 3'd3;
    localparam logic [BEAT_W-1:0] BEAT_DATA  = 3'd4;

    typedef struct packed {
        logic                 kind;
        logic [7:0]           frame_num;
        logic                 top_screen;
        logic [SIZE_BITS-1:0] total_size;
        logic [7:0]           data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       error;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } emit_t;

endpackage

@@ hdl/fpf_in_reg.sv @@
// ----------------------------------------------------------------------------
// fpf_in_reg
// Input register: holds one accepted item until the sequencer takes it.
// ----------------------------------------------------------------------------
module fpf_in_reg
    import fpf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     item_valid,
    output in_item_t item,
    input  logic     item_take
);

    logic     valid_reg;
    in_item_t data_reg;

    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (item_take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

@@ hdl/fpf_seq.sv @@
// ----------------------------------------------------------------------------
// fpf_seq
// Frame state, configuration registers and header/data sequencer.
// ----------------------------------------------------------------------------
module fpf_seq
    import fpf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 item_valid,
    input  in_item_t             item,
    output logic                 item_take,
    output emit_t                emit,
    input  logic                 out_free
);

    logic [PB_W-1:0]      payload_bytes_reg;
    logic [7:0]           max_packets_reg;
    logic [7:0]           format_code_reg;

    logic                 frame_open_reg, frame_open_next;
    logic [SIZE_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [PB_W-1:0]      chunk_left_reg, chunk_left_next;
    logic [7:0]           packet_index_reg, packet_index_next;
    logic [7:0]           frame_num_reg, frame_num_next;
    logic                 top_screen_reg, top_screen_next;
    logic [BEAT_W-1:0]    beat_reg, beat_next;

    logic [PB_W-1:0]      limit;
    logic                 last_pkt;
    logic [PB_W-1:0]      chunk;
    logic                 need_hdr;
    logic                 over;
    logic [PB_W-1:0]      chunk_dec;
    logic [SIZE_BITS-1:0] bytes_dec;
    logic [7:0]           flags;
    logic [7:0]           hdr_byte;

    // packet sizing
    always_comb begin
        if (payload_bytes_reg == '0) begin
            limit = {{(PB_W-1){1'b0}}, 1'b1};
        end else if (payload_bytes_reg > PAYLOAD_MAX) begin
            limit = PAYLOAD_MAX;
        end else begin
            limit = payload_bytes_reg;
        end
    end

    assign last_pkt  = bytes_left_reg <= {{(SIZE_BITS-PB_W){1'b0}}, limit};
    assign chunk     = last_pkt ? bytes_left_reg[PB_W-1:0] : limit;
    assign need_hdr  = chunk_left_reg == '0;
    assign over      = packet_index_reg >= max_packets_reg;
    assign chunk_dec = (need_hdr ? chunk : chunk_left_reg) - {{(PB_W-1){1'b0}}, 1'b1};
    assign bytes_dec = bytes_left_reg - {{(SIZE_BITS-1){1'b0}}, 1'b1};
    assign flags     = {7'd0, top_screen_reg} | (last_pkt ? LAST_FLAG : 8'h00);

    always_comb begin
        unique case (beat_reg)
            BEAT_ID:    hdr_byte = frame_num_reg;
            BEAT_FLAGS: hdr_byte = flags;
            BEAT_FMT:   hdr_byte = format_code_reg;
            BEAT_INDEX: hdr_byte = packet_index_reg;
            default:    hdr_byte = 8'h00;
        endcase
    end

    always_comb begin
        frame_open_next   = frame_open_reg;
        bytes_left_next   = bytes_left_reg;
        chunk_left_next   = chunk_left_reg;
        packet_index_next = packet_index_reg;
        frame_num_next    = frame_num_reg;
        top_screen_next   = top_screen_reg;
        beat_next         = beat_reg;
        item_take         = 1'b0;
        emit              = '0;

        if (item_valid) begin
            if (item.kind == KIND_START) begin
                item_take         = 1'b1;
                frame_num_next    = item.frame_num;
                top_screen_next   = item.top_screen;
                packet_index_next = 8'd0;
                chunk_left_next   = '0;
                bytes_left_next   = item.total_size;
                frame_open_next   = item.total_size != '0;
            end else if (!frame_open_reg) begin
                item_take = 1'b1;
            end else if (need_hdr && over) begin
                emit.valid      = 1'b1;
                emit.item.error = 1'b1;
                emit.item.last  = 1'b1;
                if (out_free) begin
                    item_take       = 1'b1;
                    frame_open_next = 1'b0;
                    bytes_left_next = '0;
                    chunk_left_next = '0;
                end
            end else if (need_hdr && beat_reg != BEAT_DATA) begin
                emit.valid         = 1'b1;
                emit.item.out_byte = hdr_byte;
                if (out_free) begin
                    beat_next = beat_reg + {{(BEAT_W-1){1'b0}}, 1'b1};
                end
            end else begin
                emit.valid           = 1'b1;
                emit.item.out_byte   = item.data_byte;
                emit.item.packet_end = chunk_dec == '0;
                emit.item.last       = 1'b1;
                if (out_free) begin
                    item_take       = 1'b1;
                    beat_next       = BEAT_ID;
                    chunk_left_next = chunk_dec;
                    bytes_left_next = bytes_dec;
                    if (need_hdr) begin
                        packet_index_next = packet_index_reg + 8'd1;
                    end
                    if (bytes_dec == '0) begin
                        frame_open_next = 1'b0;
                        chunk_left_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_bytes_reg <= PAYLOAD_RESET;
            max_packets_reg   <= MAX_PKT_RESET;
            format_code_reg   <= FORMAT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PAYLOAD_BYTES: payload_bytes_reg <= cfg_wdata;
                REG_MAX_PACKETS:   max_packets_reg   <= cfg_wdata[7:0];
                REG_FORMAT_CODE:   format_code_reg   <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg   <= 1'b0;
            bytes_left_reg   <= '0;
            chunk_left_reg   <= '0;
            packet_index_reg <= 8'd0;
            frame_num_reg    <= 8'd0;
            top_screen_reg   <= 1'b0;
            beat_reg         <= BEAT_ID;
        end else begin
            frame_open_reg   <= frame_open_next;
            bytes_left_reg   <= bytes_left_next;
            chunk_left_reg   <= chunk_left_next;
            packet_index_reg <= packet_index_next;
            frame_num_reg    <= frame_num_next;
            top_screen_reg   <= top_screen_next;
            beat_reg         <= beat_next;
        end
    end

    // header beats only run for a held payload byte of an open frame
    a_beat_item: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_reg != BEAT_ID |-> (item_valid && frame_open_reg && item.kind == KIND_DATA))
        else $error("header beat without open frame item");

    a_closed_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        !frame_open_reg |-> chunk_left_reg == '0)
        else $error("chunk count left over in closed frame");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.valid && emit.item.error) |-> (emit.item.last && !item_take || out_free))
        else $error("error result not final");

    a_bytes_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && item.kind == KIND_DATA && frame_open_reg && !emit.item.error)
        |=> bytes_left_reg == $past(bytes_left_reg) - {{(SIZE_BITS-1){1'b0}}, 1'b1})
        else $error("byte count not decremented");

    a_chunk_max: assert property (@(posedge aclk) disable iff (!aresetn)
        chunk_left_reg <= PAYLOAD_MAX)
        else $error("chunk count above packet limit");

endmodule

@@ hdl/fpf_out_reg.sv @@
// ----------------------------------------------------------------------------
// fpf_out_reg
// Result register: holds one result until the downstream transfer completes.
// ----------------------------------------------------------------------------
module fpf_out_reg
    import fpf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  emit_t     emit,
    output logic      out_free,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      valid_reg;
    out_item_t data_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && emit.valid) begin
            data_reg <= emit.item;
        end
    end

endmodule

@@ hdl/frame_packet_fragmenter_unit.sv @@
// path: an input transfer passes the input register, then the result register
// throughput: one payload byte per cycle while m_ready is high; a packet's first byte
//   gives four header transfers then the data byte, through the one result register
// start items and dropped bytes give no result
// reset: aresetn synchronous active low; clears frame state, empties both
//   registers and loads the configuration registers with their defaults
// ----------------------------------------------------------------------------
// frame_packet_fragmenter_unit
// Cuts a payload byte stream into packets, each opened by a four-byte header.
// ----------------------------------------------------------------------------
module frame_packet_fragmenter_unit
    import fpf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    logic     item_valid;
    in_item_t item;
    logic     item_take;
    emit_t    emit;
    logic     out_free;

    fpf_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    fpf_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .emit       (emit),
        .out_free   (out_free)
    );

    fpf_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
